/* hw/rtl/fdfr_pkg.sv */
// shared types and constants of the flood duplicate filter router
package fdfr_pkg;

  localparam logic [7:0] OWN_ADDR_RESET = 8'd2;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    MT_COMMAND   = 3'd0,
    MT_ACK       = 3'd1,
    MT_DATA      = 3'd2,
    MT_HANDSHAKE = 3'd3,
    MT_GATEWAY   = 3'd4,
    MT_NONE      = 3'd5
  } msg_e;

  typedef enum logic [2:0] {
    ROUTE_OWN       = 3'd0,
    ROUTE_DUP       = 3'd1,
    ROUTE_ACTION    = 3'd2,
    ROUTE_FORWARD   = 3'd3,
    ROUTE_DATA      = 3'd4,
    ROUTE_HANDSHAKE = 3'd5,
    ROUTE_DISCARD   = 3'd6
  } route_e;

  // class of an item as decided at the front
  typedef enum logic [2:0] {
    KIND_OWN,
    KIND_COMMAND,
    KIND_FORWARD,
    KIND_DATA,
    KIND_HANDSHAKE,
    KIND_DISCARD
  } kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } back_state_e;

  typedef struct packed {
    logic [7:0]  source_node;
    logic [15:0] sequence_number;
    logic [2:0]  message_type;
    logic [7:0]  command_id;
    logic [7:0]  command_target;
  } item_t;

  typedef struct packed {
    route_e route;
    logic   new_source;
    logic   table_full;
  } result_t;

  typedef struct packed {
    item_t item;
    kind_e kind;
  } qent_t;

endpackage

/* hw/rtl/fdfr_front.sv */
// front end: classifies accepted items and holds them in a short queue
module fdfr_front import fdfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  item_t      item_i,
  input  logic [7:0] own_addr_i,
  input  logic       pop_i,
  output logic       full_o,
  output logic       head_valid_o,
  output qent_t      head_o
);

  qent_t       mem_q [QUEUE_DEPTH];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  kind_e       kind;
  logic        do_pop;

  always_comb begin
    if (item_i.source_node == own_addr_i) begin
      kind = KIND_OWN;
    end else begin
      unique case (item_i.message_type)
        MT_COMMAND:   kind = KIND_COMMAND;
        MT_ACK:       kind = KIND_FORWARD;
        MT_DATA:      kind = KIND_DATA;
        MT_HANDSHAKE: kind = KIND_HANDSHAKE;
        default:      kind = KIND_DISCARD;
      endcase
    end
  end

  assign do_pop = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= '{item: item_i, kind: kind};
    end
  end

  assign full_o       = (count_q == 2'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

endmodule

/* hw/rtl/fdfr_back.sv */
// back end: source table search, sequence check, table update and routing
module fdfr_back import fdfr_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  qent_t      head_i,
  input  logic [7:0] own_addr_i,
  output logic       pop_o,
  output logic       result_valid_o,
  output result_t    result_o
);

  localparam int unsigned IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(POOL_ENTRIES + 1);
  localparam logic [CW-1:0] NumEntries = CW'(POOL_ENTRIES);
  localparam logic [IW-1:0] LastIdx    = IW'(POOL_ENTRIES - 1);

  // each entry holds source in the upper byte and last sequence below
  logic [23:0]             mem_q [POOL_ENTRIES];
  logic [23:0]             rd_q;
  logic [POOL_ENTRIES-1:0] valid_q, valid_d;

  back_state_e   state_q, state_d;
  logic [CW-1:0] adr_q, adr_d;
  logic          chk_q, chk_d;
  logic [IW-1:0] chk_idx_q;
  logic          hit_q, hit_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d;
  logic [15:0]   hit_seq_q, hit_seq_d;
  logic          free_q, free_d;
  logic [IW-1:0] free_idx_q, free_idx_d;
  logic [7:0]    newest_q, newest_d;
  logic          res_vld_q, res_vld_d;
  result_t       res_q, res_d;

  logic          issue;
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic          dup;
  item_t         it;

  assign it    = head_i.item;
  assign issue = (state_q == BK_SCAN) && (adr_q < NumEntries);
  assign dup   = hit_q && (it.sequence_number <= hit_seq_q);

  always_comb begin
    state_d    = state_q;
    adr_d      = adr_q;
    chk_d      = 1'b0;
    hit_d      = hit_q;
    hit_idx_d  = hit_idx_q;
    hit_seq_d  = hit_seq_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    newest_d   = newest_q;
    valid_d    = valid_q;
    res_vld_d  = 1'b0;
    res_d      = res_q;
    pop_o      = 1'b0;
    wr_en      = 1'b0;
    wr_idx     = hit_q ? hit_idx_q : free_idx_q;

    unique case (state_q)
      BK_IDLE: begin
        if (head_valid_i) begin
          if (head_i.kind == KIND_OWN) begin
            res_vld_d = 1'b1;
            res_d     = '{route: ROUTE_OWN, new_source: 1'b0, table_full: 1'b0};
            pop_o     = 1'b1;
          end else begin
            state_d = BK_SCAN;
            adr_d   = '0;
            hit_d   = 1'b0;
            free_d  = 1'b0;
          end
        end
      end
      BK_SCAN: begin
        if (issue) begin
          adr_d = adr_q + CW'(1);
          chk_d = 1'b1;
        end
        // compare the entry read in the previous cycle
        if (chk_q) begin
          if (!valid_q[chk_idx_q] && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = chk_idx_q;
          end
          if (valid_q[chk_idx_q] && (rd_q[23:16] == it.source_node)) begin
            hit_d     = 1'b1;
            hit_idx_d = chk_idx_q;
            hit_seq_d = rd_q[15:0];
            state_d   = BK_FINISH;
          end else if (chk_idx_q == LastIdx) begin
            state_d = BK_FINISH;
          end
        end
      end
      BK_FINISH: begin
        pop_o     = 1'b1;
        res_vld_d = 1'b1;
        state_d   = BK_IDLE;
        if (dup) begin
          res_d = '{route: ROUTE_DUP, new_source: 1'b0, table_full: 1'b0};
        end else begin
          wr_en              = hit_q || free_q;
          res_d.new_source   = !hit_q;
          res_d.table_full   = !hit_q && !free_q;
          if (!hit_q && free_q) begin
            valid_d[free_idx_q] = 1'b1;
          end
          unique case (head_i.kind)
            KIND_COMMAND: begin
              if ((it.command_id > newest_q) && (it.command_target == own_addr_i)) begin
                res_d.route = ROUTE_ACTION;
                newest_d    = it.command_id;
              end else begin
                res_d.route = ROUTE_FORWARD;
              end
            end
            KIND_FORWARD:   res_d.route = ROUTE_FORWARD;
            KIND_DATA:      res_d.route = ROUTE_DATA;
            KIND_HANDSHAKE: res_d.route = ROUTE_HANDSHAKE;
            default:        res_d.route = ROUTE_DISCARD;
          endcase
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      adr_q     <= '0;
      chk_q     <= 1'b0;
      hit_q     <= 1'b0;
      free_q    <= 1'b0;
      newest_q  <= 8'd0;
      valid_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      adr_q     <= adr_d;
      chk_q     <= chk_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      newest_q  <= newest_d;
      valid_q   <= valid_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= adr_q[IW-1:0];
    hit_idx_q  <= hit_idx_d;
    hit_seq_q  <= hit_seq_d;
    free_idx_q <= free_idx_d;
    res_q      <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q <= mem_q[adr_q[IW-1:0]];
    end
    if (wr_en) begin
      mem_q[wr_idx] <= {it.source_node, it.sequence_number};
    end
  end

  assign result_valid_o = res_vld_q;
  assign result_o       = res_q;

endmodule

/* hw/rtl/flood_duplicate_filter_router.sv */
// top level of the flood duplicate filter router
// Takes one received packet header per start pulse while busy is low and
// returns exactly one routing decision, shown for a single cycle with
// result_valid_o high; the result cannot be held off, so the receiver must
// take it when it appears. A packet from this node's own address skips the
// source table. Any other packet walks the source table one entry per cycle
// through the table's single read port, stopping once its source is found.
// A two-item queue sits in front of the table logic, so busy only rises
// while two items wait. own_address is written through cfg_we_i / cfg_data_i
// and resets to address 2; the user must write it only while the block is
// idle, as the block does not enforce this.
module flood_duplicate_filter_router import fdfr_pkg::*; #(
  parameter int unsigned POOL_ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  item_t      item_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  output logic       result_valid_o,
  output result_t    result_o
);

  logic [7:0] own_addr_q;
  logic       head_valid;
  qent_t      head;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q <= OWN_ADDR_RESET;
    end else if (cfg_we_i) begin
      own_addr_q <= cfg_data_i;
    end
  end

  fdfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (start && !busy),
    .item_i       (item_i),
    .own_addr_i   (own_addr_q),
    .pop_i        (pop),
    .full_o       (busy),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  fdfr_back #(
    .POOL_ENTRIES (POOL_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .own_addr_i     (own_addr_q),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule
